// ===== rtl/pbd_pkg.sv =====
// PackBits bitmap decoder: shared types and constants.
// No dependencies; imported by the interfaces and all modules.
package pbd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RepW    = 4;
  localparam int unsigned RowW    = 10;
  localparam int unsigned ColW    = 7;
  localparam int unsigned RunW    = 8;
  localparam int unsigned SegIdxW = 5;
  localparam int unsigned MaxRes  = 20;

  localparam logic [RowW-1:0] RowsReset = 10'd720;
  localparam logic [RunW:0]   RepBase   = 9'd257;

  localparam logic [1:0] PhCount   = 2'd0;
  localparam logic [1:0] PhLiteral = 2'd1;
  localparam logic [1:0] PhRepeat  = 2'd2;

  typedef struct packed {
    logic accept;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic data_phase;
    logic active;
    logic finish;
    logic cap;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/pbd_if.sv =====
// PackBits bitmap decoder: valid/ready channel interfaces.
// Depends on pbd_pkg.
interface pbd_in_if;
  import pbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  pixel_byte;
  logic [RepW-1:0]   repeat_count;
  logic [RowW-1:0]   row;
  logic [ColW-1:0]   column;
  logic              image_done;
  logic              last;
  modport source (output valid, output pixel_byte, output repeat_count, output row,
                  output column, output image_done, output last, input ready);
  modport sink   (input valid, input pixel_byte, input repeat_count, input row,
                  input column, input image_done, input last, output ready);
endinterface

// ===== rtl/packbits_bitmap_decoder_core.sv =====
// PackBits bitmap decoder, top level. Depends on pbd_pkg, pbd_if, pbd_ctrl, pbd_datapath.
// Count bytes are taken and give no result. A data byte is taken, then one segment per
// cycle goes to the output register; no new byte is taken until the byte's segment loop
// is over (a byte past the image end still enters the segment loop).
// The segment loop in the controller sets the rate; output stalls hold it.
// Reset (async, active low) clears parse state and position; row limit returns to 720.
module packbits_bitmap_decoder_core #(
  parameter int unsigned ROW_BYTES = 72,
  parameter int unsigned MAX_ROWS  = 720
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pbd_pkg::RowW-1:0] cfg_wdata_i,
  pbd_in_if.sink                   in_i,
  pbd_out_if.source                out_o
);
  import pbd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  pbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbd_datapath #(
    .ROW_BYTES (ROW_BYTES),
    .MAX_ROWS  (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .stream_byte_i (in_i.stream_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_o         (out_o)
  );

endmodule

// ===== rtl/pbd_ctrl.sv =====
// PackBits bitmap decoder: control state machine.
// Depends on pbd_pkg; drives pbd_datapath through cmd_t, reads sts_t.
module pbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pbd_pkg::sts_t sts_i,
  output pbd_pkg::cmd_t cmd_o
);
  import pbd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.data_phase) state_d = StRun;
      end
      StRun: begin
        if (!sts_i.active) begin
          state_d = StIdle;
        end else if (sts_i.slot_free) begin
          cmd_o.step = 1'b1;
          cmd_o.emit = 1'b1;
          if (sts_i.finish) state_d = StIdle;
          else if (sts_i.cap) state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.active) cmd_o.step = 1'b1;
        else state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.active && sts_i.slot_free)
    else $error("segment emitted with no run pending or output full");

endmodule

// ===== rtl/pbd_datapath.sv =====
// PackBits bitmap decoder: parse state, position counters, segment maths, output register.
// Depends on pbd_pkg and pbd_out_if; commanded by pbd_ctrl.
module pbd_datapath #(
  parameter int unsigned ROW_BYTES = 72,
  parameter int unsigned MAX_ROWS  = 720
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pbd_pkg::RowW-1:0]  cfg_wdata_i,
  input  logic [pbd_pkg::ByteW-1:0] stream_byte_i,
  input  pbd_pkg::cmd_t             cmd_i,
  output pbd_pkg::sts_t             sts_o,
  pbd_out_if.source                 out_o
);
  import pbd_pkg::*;

  localparam logic [RunW-1:0] RowBytesW = RunW'(ROW_BYTES);
  localparam logic [RowW-1:0] MaxRowsW  = RowW'(MAX_ROWS);
  localparam logic [RunW-1:0] SegMax    = RunW'(8);

  logic [1:0]         phase_q;
  logic [RunW-1:0]    run_left_q;
  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic [RunW-1:0]    cnt_q;
  logic [ByteW-1:0]   byte_q;
  logic [SegIdxW-1:0] seg_idx_q;
  logic [RowW-1:0]    rows_q;
  logic               out_valid_q;

  logic [RowW-1:0] lim;
  logic [RunW-1:0] room, seg, col_sum, cnt_nx;
  logic [RowW-1:0] row_nx;
  logic            wrap, done;

  always_comb begin
    lim     = (rows_q < MaxRowsW) ? rows_q : MaxRowsW;
    room    = RowBytesW - {1'b0, col_q};
    seg     = (cnt_q < SegMax) ? cnt_q : SegMax;
    if (room < seg) seg = room;
    col_sum = {1'b0, col_q} + seg;
    wrap    = col_sum >= RowBytesW;
    row_nx  = row_q + RowW'(wrap);
    cnt_nx  = cnt_q - seg;
    done    = row_nx >= lim;
  end

  assign sts_o.data_phase = (phase_q == PhLiteral) || (phase_q == PhRepeat);
  assign sts_o.active     = (cnt_q != '0) && (row_q < lim);
  assign sts_o.finish     = (cnt_nx == '0) || done;
  assign sts_o.cap        = seg_idx_q == SegIdxW'(MaxRes - 1);
  assign sts_o.slot_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= RowsReset;
      phase_q     <= PhCount;
      run_left_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      seg_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rows_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        seg_idx_q <= '0;
        unique case (phase_q)
          PhLiteral: begin
            cnt_q <= RunW'(1);
            if (run_left_q != '0) run_left_q <= run_left_q - RunW'(1);
            if (run_left_q <= RunW'(1)) phase_q <= PhCount;
          end
          PhRepeat: begin
            cnt_q      <= run_left_q;
            run_left_q <= '0;
            phase_q    <= PhCount;
          end
          default: begin
            if (!stream_byte_i[ByteW-1]) begin
              run_left_q <= stream_byte_i + RunW'(1);
              phase_q    <= PhLiteral;
            end else begin
              run_left_q <= RunW'(RepBase - {1'b0, stream_byte_i});
              phase_q    <= PhRepeat;
            end
          end
        endcase
      end
      if (cmd_i.step) begin
        col_q <= wrap ? '0 : col_sum[ColW-1:0];
        row_q <= row_nx;
        cnt_q <= cnt_nx;
      end
      if (cmd_i.emit) seg_idx_q <= seg_idx_q + SegIdxW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) byte_q <= stream_byte_i;
    if (cmd_i.emit) begin
      out_o.pixel_byte   <= byte_q;
      out_o.repeat_count <= seg[RepW-1:0];
      out_o.row          <= row_q;
      out_o.column       <= col_q;
      out_o.image_done   <= done;
      out_o.last         <= sts_o.finish || sts_o.cap;
    end
  end

  assign out_o.valid = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < RowBytesW)
    else $error("column beyond row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (seg != '0) && (seg <= SegMax))
    else $error("segment length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (cnt_q <= $past(cnt_q)))
    else $error("run count grew while stepping");

endmodule

// ===== tb/tb_packbits_bitmap_decoder_core.sv =====
// Testbench for packbits_bitmap_decoder_core: streams compressed byte transactions
// into the decoder and checks every output segment against a behavioural predictor.
// Depends on pbd_pkg, pbd_if and the decoder RTL.
module tb_packbits_bitmap_decoder_core;
  import pbd_pkg::*;

  localparam int unsigned RowBytes     = 72;
  localparam int unsigned MaxRows      = 720;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PrintLimit   = 40;
  localparam logic [ByteW-1:0] RepeatFlag  = 8'h80;
  localparam logic [ByteW-1:0] LongLiteral = 8'h7F;
  localparam logic [RowW-1:0]  RowsTop     = 10'd1023;

  typedef enum logic [1:0] {RxFree, RxPattern, RxRandom} rx_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] pixel_byte;
    logic [RepW-1:0]  repeat_count;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  column;
    logic             image_done;
    logic             last;
  } seg_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [RowW-1:0]  cfg_wdata = '0;
  logic             tx_valid  = 1'b0;
  logic [ByteW-1:0] tx_byte   = '0;
  logic             rx_ready  = 1'b0;

  pbd_in_if  byte_if ();
  pbd_out_if seg_if ();

  assign byte_if.valid       = tx_valid;
  assign byte_if.stream_byte = tx_byte;
  assign seg_if.ready        = rx_ready;

  packbits_bitmap_decoder_core #(
    .ROW_BYTES(RowBytes),
    .MAX_ROWS (MaxRows)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (byte_if),
    .out_o      (seg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decoder shadow state
  logic [RowW-1:0] rows_cfg   = RowsReset;
  logic [1:0]      dec_phase  = PhCount;
  logic [RunW-1:0] run_left   = '0;
  int unsigned     col_pos    = 0;
  int unsigned     row_pos    = 0;
  seg_t            expected_segs[$];
  int unsigned     mismatches = 0;

  // Sender and receiver pacing
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 0;
  rx_mode_e    rx_mode     = RxFree;
  int unsigned hold_ticket = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  logic [15:0] rx_pattern  = 16'hA5C3;
  int unsigned rx_tick     = 0;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PrintLimit)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    mismatches++;
  endtask

  function automatic void place_run(input logic [ByteW-1:0] b, input int unsigned cnt);
    int unsigned lim;
    int unsigned seg;
    int unsigned n;
    seg_t        s;
    lim = (rows_cfg < MaxRows) ? int'(rows_cfg) : MaxRows;
    n = 0;
    while (cnt > 0 && row_pos < lim) begin
      seg = (cnt < 8) ? cnt : 8;
      if (RowBytes - col_pos < seg) seg = RowBytes - col_pos;
      s.pixel_byte   = b;
      s.repeat_count = RepW'(seg);
      s.row          = RowW'(row_pos);
      s.column       = ColW'(col_pos);
      s.last         = 1'b0;
      col_pos += seg;
      cnt     -= seg;
      if (col_pos >= RowBytes) begin
        col_pos = 0;
        row_pos++;
      end
      s.image_done = (row_pos >= lim);
      if (n < MaxRes) expected_segs.push_back(s);
      n++;
    end
    if (n > 0) begin
      s = expected_segs.pop_back();
      s.last = 1'b1;
      expected_segs.push_back(s);
    end
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] b);
    case (dec_phase)
      PhLiteral: begin
        place_run(b, 1);
        if (run_left != 0) run_left--;
        if (run_left == 0) dec_phase = PhCount;
      end
      PhRepeat: begin
        place_run(b, int'(run_left));
        run_left  = '0;
        dec_phase = PhCount;
      end
      default: begin
        if (b < RepeatFlag) begin
          run_left  = RunW'(b + 1'b1);
          dec_phase = PhLiteral;
        end else begin
          run_left  = RunW'(RepBase - {1'b0, b});
          dec_phase = PhRepeat;
        end
      end
    endcase
  endfunction

  // Segment checker
  always @(posedge clk_i) begin : seg_check
    seg_t got;
    seg_t want;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      got = '{seg_if.pixel_byte, seg_if.repeat_count, seg_if.row, seg_if.column,
              seg_if.image_done, seg_if.last};
      if (expected_segs.size() == 0) begin
        report_mismatch("segment with none pending, pixel_byte", 0, 32'(got.pixel_byte));
      end else begin
        want = expected_segs.pop_front();
        if (got.pixel_byte != want.pixel_byte)
          report_mismatch("pixel_byte", 32'(want.pixel_byte), 32'(got.pixel_byte));
        if (got.repeat_count != want.repeat_count)
          report_mismatch("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
        if (got.row != want.row)
          report_mismatch("row", 32'(want.row), 32'(got.row));
        if (got.column != want.column)
          report_mismatch("column", 32'(want.column), 32'(got.column));
        if (got.image_done != want.image_done)
          report_mismatch("image_done", 32'(want.image_done), 32'(got.image_done));
        if (got.last != want.last)
          report_mismatch("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  // Output back-pressure
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HoldCycles;
    end
    rx_tick++;
    if (rx_tick % 64 == 0) rx_pattern = 16'($urandom) | 16'h0101;
    if (hold_left != 0) begin
      rx_ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RxFree:    rx_ready <= 1'b1;
        RxPattern: begin
          rx_ready   <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
        default:   rx_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    tx_valid <= 1'b1;
    tx_byte  <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    burst_left--;
    decode_byte(b);
  endtask

  task automatic wait_drain();
    tx_valid <= 1'b0;
    burst_left = 0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_rows(input logic [RowW-1:0] v);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    rows_cfg = v;
  endtask

  task automatic send_random_mix(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_byte(ByteW'($urandom));
        sent++;
      end else if (pick < 55) begin
        len = (pick < 15) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        send_byte(ByteW'(len - 1));
        repeat (len) send_byte(ByteW'($urandom));
        sent += len + 1;
      end else begin
        send_byte(ByteW'($urandom_range(128, 255)));
        send_byte(ByteW'($urandom));
        sent += 2;
      end
    end
  endtask

  // Single-row image: first repeat completes it, the rest is dropped
  task automatic test_limit_one();
    write_rows(10'd1);
    send_byte(RepeatFlag);
    send_byte(8'h3C);
    send_byte(8'h00);
    send_byte(8'h11);
  endtask

  task automatic test_run_kinds();
    write_rows(RowsReset);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h81);
    send_byte(8'h80);
    send_byte(8'h03);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(RepeatFlag);
    send_byte(8'h55);
  endtask

  // Limit dropped below the current row, then to zero: nothing more comes out
  task automatic test_limit_lowered();
    write_rows(10'd1);
    send_byte(8'h85);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h12);
    send_byte(8'h34);
    write_rows('0);
    send_byte(8'h00);
    send_byte(8'h99);
  endtask

  task automatic test_long_literal();
    write_rows(RowsTop);
    rx_mode = RxPattern;
    gap_max = 4;
    send_byte(LongLiteral);
    repeat (128) send_byte(ByteW'($urandom));
    send_random_mix(10);
  endtask

  task automatic test_backpressure();
    rx_mode = RxRandom;
    gap_max = 0;
    hold_ticket++;
    repeat (12) begin
      send_byte(ByteW'($urandom_range(128, 144)));
      send_byte(ByteW'($urandom));
    end
    wait_drain();
    send_random_mix(10);
  endtask

  task automatic test_random_limits();
    write_rows(RowW'(row_pos + 2));
    rx_mode = RxRandom;
    gap_max = 3;
    send_random_mix(20);
    write_rows(RowW'($urandom_range(0, 1023)));
    rx_mode = RxFree;
    gap_max = 0;
    send_random_mix(15);
    write_rows(RowW'(row_pos + 1));
    rx_mode = RxPattern;
    gap_max = 6;
    send_random_mix(15);
    write_rows(RowsReset);
    rx_mode = RxRandom;
    gap_max = 2;
    send_random_mix(10);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_limit_one();
    test_run_kinds();
    test_limit_lowered();
    test_long_literal();
    test_backpressure();
    test_random_limits();
    wait_drain();
    if (mismatches == 0) begin
      $display("tb_packbits_bitmap_decoder_core: PASS");
    end else begin
      $display("tb_packbits_bitmap_decoder_core: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_packbits_bitmap_decoder_core: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pbd_pkg.sv
rtl/pbd_if.sv
rtl/pbd_ctrl.sv
rtl/pbd_datapath.sv
rtl/packbits_bitmap_decoder_core.sv
tb/tb_packbits_bitmap_decoder_core.sv
